// ===== rtl/cle_pkg.sv =====
package cle_pkg;

  localparam int LINE_LEN_DEF = 64;
  localparam int KEY_W        = 56;
  localparam int IDX_W        = 6;
  localparam int POS_W        = 7;
  localparam int BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7e;

  localparam logic [KEY_W-1:0] KEY_ESC    = 56'h1b;
  localparam logic [KEY_W-1:0] KEY_BKSP   = 56'h7f;
  localparam logic [KEY_W-1:0] KEY_ENTER  = 56'h0a;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 56'h1b5b43;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 56'h1b5b44;
  localparam logic [KEY_W-1:0] KEY_HOME   = 56'h1b5b48;
  localparam logic [KEY_W-1:0] KEY_END    = 56'h1b5b46;
  localparam logic [KEY_W-1:0] KEY_DEL    = 56'h1b5b337e;
  localparam logic [KEY_W-1:0] KEY_CRIGHT = 56'h1b5b313b3543;
  localparam logic [KEY_W-1:0] KEY_CLEFT  = 56'h1b5b313b3544;

endpackage

// ===== rtl/cle_ram.sv =====
module cle_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/command_line_editor_core.sv =====
// Line editor: holds one line of up to LINE_LEN bytes plus a cursor and takes one key word
// (terminal escape sequence, first byte highest) or one read command per start. Cursor
// keys, home, end, escape, enter, unknown keys and an insert at the line end finish
// straight from the idle state, a read through the RD state. Edits that shift bytes and
// word jumps walk the line store through its one read port and one write port, one byte
// per cycle: insert through SHR then INS, backspace and delete through SHL, word jumps
// through WRT or WLF. done pulses for one cycle with the result; the receiver cannot
// stall it. A new start is taken in the cycle done is high.
module command_line_editor_core import cle_pkg::*; #(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic [KEY_W-1:0]  key_code,
  input  logic [IDX_W-1:0]  read_index,
  output logic              done,
  output logic              key_used,
  output logic [POS_W-1:0]  cursor_now,
  output logic [POS_W-1:0]  line_length,
  output logic [BYTE_W-1:0] read_byte,
  output logic              overflow
);

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int AW = $clog2(LINE_LEN);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    IDLE, RD, WRT, WLF, SHL, SHR, INS
  } state_t;

  state_t            state;
  logic [CW-1:0]     cursor, length, dpos;
  logic              prev_sp, have_prev, rd_ok;
  logic [BYTE_W-1:0] ins_byte;

  logic [CW-1:0]     cur_inc, cur_dec, len_inc, len_dec, dpos_inc, dpos_dec;
  logic [XW-1:0]     ridx_x;
  logic              ridx_hit, len_full, rd_sp;
  logic              is_esc, is_left, is_right, is_home, is_end, is_bksp, is_del;
  logic              is_enter, is_cright, is_cleft, is_print;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  cle_ram #(.W(BYTE_W), .D(LINE_LEN)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_inc  = cursor + CW'(1);
  assign cur_dec  = cursor - CW'(1);
  assign len_inc  = length + CW'(1);
  assign len_dec  = length - CW'(1);
  assign dpos_inc = dpos + CW'(1);
  assign dpos_dec = dpos - CW'(1);
  assign ridx_x   = XW'(read_index);
  assign ridx_hit = ridx_x < XW'(length);
  assign len_full = length == CW'(LINE_LEN);
  // line end reads as non-space
  assign rd_sp    = (dpos < length) && (ram_rdata == CHAR_SPACE);

  assign is_esc    = key_code == KEY_ESC;
  assign is_left   = key_code == KEY_LEFT;
  assign is_right  = key_code == KEY_RIGHT;
  assign is_home   = key_code == KEY_HOME;
  assign is_end    = key_code == KEY_END;
  assign is_bksp   = key_code == KEY_BKSP;
  assign is_del    = key_code == KEY_DEL;
  assign is_enter  = key_code == KEY_ENTER;
  assign is_cright = key_code == KEY_CRIGHT;
  assign is_cleft  = key_code == KEY_CLEFT;
  assign is_print  = (key_code >= KEY_W'(CHAR_SPACE)) && (key_code <= KEY_W'(CHAR_TILDE));

  assign busy        = state != IDLE;
  assign cursor_now  = POS_W'(cursor);
  assign line_length = POS_W'(length);

  // memory port: shifts read two positions ahead of the write, never the same entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      IDLE: begin
        priority if (command) begin
          ram_raddr = ridx_x[AW-1:0];
        end else if (is_cright || is_bksp) begin
          ram_raddr = cursor[AW-1:0];
        end else if (is_cleft) begin
          ram_raddr = cur_dec[AW-1:0];
        end else if (is_del) begin
          ram_raddr = cur_inc[AW-1:0];
        end else if (is_enter) begin
          ram_we    = start && !len_full;
          ram_waddr = length[AW-1:0];
          ram_wdata = CHAR_SPACE;
        end else if (is_print) begin
          if (cursor == length) begin
            ram_we    = start && !len_full;
            ram_waddr = cursor[AW-1:0];
            ram_wdata = key_code[BYTE_W-1:0];
          end else begin
            ram_raddr = len_dec[AW-1:0];
          end
        end else begin
          ram_raddr = '0;
        end
      end
      RD: ;
      WRT: ram_raddr = dpos_inc[AW-1:0];
      WLF: ram_raddr = dpos_dec[AW-1:0];
      SHL: begin
        ram_we    = 1'b1;
        ram_waddr = dpos_dec[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = dpos_inc[AW-1:0];
      end
      SHR: begin
        ram_we    = 1'b1;
        ram_waddr = dpos_inc[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = dpos_dec[AW-1:0];
      end
      INS: begin
        ram_we    = 1'b1;
        ram_waddr = cursor[AW-1:0];
        ram_wdata = ins_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cursor    <= '0;
      length    <= '0;
      done      <= 1'b0;
      key_used  <= 1'b0;
      overflow  <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            key_used  <= 1'b1;
            overflow  <= 1'b0;
            read_byte <= '0;
            priority if (command) begin
              key_used <= 1'b0;
              rd_ok    <= ridx_hit;
              state    <= RD;
            end else if (is_esc) begin
              cursor <= '0;
              length <= '0;
              done   <= 1'b1;
            end else if (is_left) begin
              if (cursor != '0) cursor <= cur_dec;
              done <= 1'b1;
            end else if (is_right) begin
              if (cursor < length) cursor <= cur_inc;
              done <= 1'b1;
            end else if (is_home) begin
              cursor <= '0;
              done   <= 1'b1;
            end else if (is_end) begin
              cursor <= length;
              done   <= 1'b1;
            end else if (is_bksp) begin
              if (cursor == '0) begin
                done <= 1'b1;
              end else begin
                cursor <= cur_dec;
                if (cursor < length) begin
                  dpos  <= cursor;
                  state <= SHL;
                end else begin
                  length <= len_dec;
                  done   <= 1'b1;
                end
              end
            end else if (is_del) begin
              if (cursor < length && cur_inc < length) begin
                dpos  <= cur_inc;
                state <= SHL;
              end else begin
                if (cursor < length) length <= len_dec;
                done <= 1'b1;
              end
            end else if (is_enter) begin
              if (len_full) begin
                overflow <= 1'b1;
              end else begin
                length <= len_inc;
                cursor <= len_inc;
              end
              done <= 1'b1;
            end else if (is_cright) begin
              if (cursor < length) begin
                dpos      <= cursor;
                have_prev <= 1'b0;
                state     <= WRT;
              end else begin
                done <= 1'b1;
              end
            end else if (is_cleft) begin
              if (cursor > CW'(1)) begin
                dpos      <= cur_dec;
                have_prev <= 1'b0;
                state     <= WLF;
              end else begin
                cursor <= '0;
                done   <= 1'b1;
              end
            end else if (is_print) begin
              if (len_full) begin
                overflow <= 1'b1;
                done     <= 1'b1;
              end else if (cursor == length) begin
                length <= len_inc;
                cursor <= cur_inc;
                done   <= 1'b1;
              end else begin
                ins_byte <= key_code[BYTE_W-1:0];
                dpos     <= len_dec;
                state    <= SHR;
              end
            end else begin
              key_used <= 1'b0;
              done     <= 1'b1;
            end
          end
        end
        RD: begin
          read_byte <= rd_ok ? ram_rdata : '0;
          done      <= 1'b1;
          state     <= IDLE;
        end
        SHL: begin
          if (dpos_inc < length) begin
            dpos <= dpos_inc;
          end else begin
            length <= len_dec;
            done   <= 1'b1;
            state  <= IDLE;
          end
        end
        SHR: begin
          if (dpos > cursor) dpos <= dpos_dec;
          else state <= INS;
        end
        INS: begin
          length <= len_inc;
          cursor <= cur_inc;
          done   <= 1'b1;
          state  <= IDLE;
        end
        WRT: begin
          // stop on a word start: space behind, non-space here, or line end
          if (!have_prev) begin
            prev_sp   <= rd_sp;
            have_prev <= 1'b1;
            dpos      <= dpos_inc;
          end else if ((prev_sp && !rd_sp) || dpos == length) begin
            cursor <= dpos;
            done   <= 1'b1;
            state  <= IDLE;
          end else begin
            prev_sp <= rd_sp;
            dpos    <= dpos_inc;
          end
        end
        WLF: begin
          // prev_sp holds the space flag of dpos + 1
          if (!have_prev) begin
            prev_sp   <= rd_sp;
            have_prev <= 1'b1;
            dpos      <= dpos_dec;
          end else if (rd_sp && !prev_sp) begin
            cursor <= dpos_inc;
            done   <= 1'b1;
            state  <= IDLE;
          end else if (dpos == '0) begin
            cursor <= '0;
            done   <= 1'b1;
            state  <= IDLE;
          end else begin
            prev_sp <= rd_sp;
            dpos    <= dpos_dec;
          end
        end
      endcase
    end
  end

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    length <= CW'(LINE_LEN) && cursor <= length)
    else $error("cursor or length out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while still busy");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted word produced neither result nor work");

  a_ovf_used: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> key_used)
    else $error("overflow flagged on unused key");

endmodule

// ===== dv/command_line_editor_core_test.sv =====
`timescale 1ns / 100ps

module command_line_editor_core_test;
  import cle_pkg::*;

  localparam int LINE_LEN   = LINE_LEN_DEF;
  localparam int WORDS      = 700;
  localparam int DRAIN      = 2 * LINE_LEN + 16;
  localparam int STALL_MAX  = 4000;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              used;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  len;
    logic [BYTE_W-1:0] rbyte;
    logic              ovf;
  } line_view_t;

  // shadow copy of the edit line; predicts the view after each word
  class line_scoreboard;
    logic [BYTE_W-1:0] line_buf [LINE_LEN];
    int cur;
    int len;
    int hi_water;   // entries below this have been written at least once
    int acted;
    int errors;
    line_view_t pending_views[$];

    task report(string msg);
      if (errors < 200) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit space_at(int p);
      if (p >= len || p >= LINE_LEN) return 1'b0;
      return line_buf[p] == CHAR_SPACE;
    endfunction

    function void drop_at(int p);
      if (p >= len) return;
      for (int i = p; i + 1 < len; i++) line_buf[i] = line_buf[i + 1];
      len--;
    endfunction

    // 1 when the line is full and the byte is dropped
    function bit put_at(int p, logic [BYTE_W-1:0] b);
      if (len >= LINE_LEN) return 1'b1;
      if (p > len) p = len;
      for (int i = len; i > p; i--) line_buf[i] = line_buf[i - 1];
      line_buf[p] = b;
      len++;
      return 1'b0;
    endfunction

    function line_view_t apply_word(cmd_e cmd, logic [KEY_W-1:0] key, logic [IDX_W-1:0] idx);
      line_view_t v;
      bit found;
      v = '0;
      v.used = 1'b1;
      found = 1'b0;
      if (cmd == CMD_READ) begin
        v.used = 1'b0;
        if (int'(idx) < len) v.rbyte = line_buf[idx];
      end else if (key == KEY_ESC) begin
        len = 0;
        cur = 0;
      end else if (key == KEY_LEFT) begin
        if (cur > 0) cur--;
      end else if (key == KEY_RIGHT) begin
        if (cur < len) cur++;
      end else if (key == KEY_HOME) begin
        cur = 0;
      end else if (key == KEY_END) begin
        cur = len;
      end else if (key == KEY_BKSP) begin
        if (cur > 0) begin
          cur--;
          drop_at(cur);
        end
      end else if (key == KEY_DEL) begin
        if (cur < len) drop_at(cur);
      end else if (key == KEY_ENTER) begin
        v.ovf = put_at(len, CHAR_SPACE);
        if (!v.ovf) cur = len;
      end else if (key == KEY_CRIGHT) begin
        while (!found && cur < len) begin
          cur++;
          found = space_at(cur - 1) && !space_at(cur);
        end
      end else if (key == KEY_CLEFT) begin
        while (!found && cur > 1) begin
          cur--;
          found = space_at(cur - 1) && !space_at(cur);
        end
        if (!found) cur = 0;
      end else if (key >= KEY_W'(CHAR_SPACE) && key <= KEY_W'(CHAR_TILDE)) begin
        v.ovf = put_at(cur, key[BYTE_W-1:0]);
        if (!v.ovf) cur++;
      end else begin
        v.used = 1'b0;
      end
      v.cur = POS_W'(cur);
      v.len = POS_W'(len);
      if (len > hi_water) hi_water = len;
      return v;
    endfunction

    function void note_word(cmd_e cmd, logic [KEY_W-1:0] key, logic [IDX_W-1:0] idx);
      line_view_t v;
      v = apply_word(cmd, key, idx);
      pending_views.push_back(v);
      if (v.used || cmd == CMD_READ) acted++;
    endfunction

    task check_result(logic used, logic [POS_W-1:0] c, logic [POS_W-1:0] n,
                      logic [BYTE_W-1:0] b, logic ovf);
      line_view_t want;
      string diff;
      if (pending_views.size() == 0) begin
        report($sformatf("result with nothing pending: used=%b cursor=%0d length=%0d",
                         used, c, n));
        return;
      end
      want = pending_views.pop_front();
      diff = "";
      if (used !== want.used)
        diff = {diff, $sformatf(" key_used %b exp %b", used, want.used)};
      if (c !== want.cur)
        diff = {diff, $sformatf(" cursor_now %0d exp %0d", c, want.cur)};
      if (n !== want.len)
        diff = {diff, $sformatf(" line_length %0d exp %0d", n, want.len)};
      if (b !== want.rbyte)
        diff = {diff, $sformatf(" read_byte %h exp %h", b, want.rbyte)};
      if (ovf !== want.ovf)
        diff = {diff, $sformatf(" overflow %b exp %b", ovf, want.ovf)};
      if (diff != "") report({"wrong result:", diff});
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              command = 1'b0;
  logic [KEY_W-1:0]  key_code = '0;
  logic [IDX_W-1:0]  read_index = '0;
  logic              busy;
  logic              done;
  logic              key_used;
  logic [POS_W-1:0]  cursor_now;
  logic [POS_W-1:0]  line_length;
  logic [BYTE_W-1:0] read_byte;
  logic              overflow;

  line_scoreboard sb = new;
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;

  command_line_editor_core #(.LINE_LEN(LINE_LEN)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key_code   (key_code),
    .read_index (read_index),
    .done       (done),
    .key_used   (key_used),
    .cursor_now (cursor_now),
    .line_length(line_length),
    .read_byte  (read_byte),
    .overflow   (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done === 1'b1) sb.check_result(key_used, cursor_now, line_length, read_byte, overflow);
      if ((start && busy === 1'b0) || done === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_MAX) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] nav_key(int sel);
    case (sel)
      0: return KEY_LEFT;
      1: return KEY_RIGHT;
      2: return KEY_HOME;
      3: return KEY_END;
      4: return KEY_CLEFT;
      default: return KEY_CRIGHT;
    endcase
  endfunction

  // random gap first, then hold start until the word is taken
  task automatic issue(cmd_e cmd, logic [KEY_W-1:0] key, logic [IDX_W-1:0] idx);
    if (!no_gaps && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    key_code   <= key;
    read_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(cmd, key, idx);
  endtask

  task automatic press(logic [KEY_W-1:0] key);
    issue(CMD_KEY, key, IDX_W'($urandom));
  endtask

  task automatic read_at(logic [IDX_W-1:0] idx);
    issue(CMD_READ, rand_bits(), idx);
  endtask

  initial begin
    int kind;
    int n;
    bit paused;
    bit filled;
    logic [KEY_W-1:0] k;

    paused = 1'b0;
    filled = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // edges on an empty line, unknown codes
    press(KEY_LEFT);
    press(KEY_BKSP);
    press(KEY_DEL);
    press(KEY_RIGHT);
    press(KEY_CLEFT);
    press(KEY_CRIGHT);
    press('0);
    press(56'h09);
    press(56'h1b5b41);
    press('1);
    press(56'h1f);
    press(56'h80);
    // "a ~x" then enter appends a space
    press(56'h61);
    press(KEY_W'(CHAR_SPACE));
    press(KEY_W'(CHAR_TILDE));
    press(56'h78);
    press(KEY_ENTER);
    read_at(6'd0);
    read_at(6'd4);
    press(KEY_HOME);
    press(KEY_CRIGHT);
    press(KEY_CRIGHT);
    press(KEY_END);
    press(KEY_CLEFT);
    press(KEY_LEFT);
    press(KEY_DEL);
    press(KEY_BKSP);
    press(KEY_ESC);
    read_at(6'd2);

    while (sb.acted < WORDS) begin
      no_gaps = (sb.acted >= 300 && sb.acted < 450);
      if ((!paused && sb.acted >= 200) || $urandom_range(0, 99) == 0) begin
        start <= 1'b0;
        while (sb.pending_views.size() != 0) @(posedge clk);
        @(posedge clk);
        paused = 1'b1;
      end
      kind = filled ? $urandom_range(0, 99) : 94;
      if (kind < 35) begin
        repeat ($urandom_range(1, 8)) press(KEY_W'($urandom_range(8'h21, 8'h7e)));
        press(KEY_W'(CHAR_SPACE));
        if ($urandom_range(0, 3) == 0) press(KEY_W'(CHAR_SPACE));
      end else if (kind < 53) begin
        repeat ($urandom_range(1, 5)) press(nav_key($urandom_range(0, 5)));
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 10)) press($urandom_range(0, 1) ? KEY_BKSP : KEY_DEL);
      end else if (kind < 76) begin
        if (sb.hi_water > 0) begin
          repeat ($urandom_range(1, 4)) begin
            if (sb.len > 0 && $urandom_range(0, 1))
              read_at(IDX_W'($urandom_range(0, sb.len - 1)));
            else
              read_at(IDX_W'($urandom_range(0, sb.hi_water - 1)));
          end
        end
      end else if (kind < 81) begin
        press(KEY_ENTER);
      end else if (kind < 88) begin
        // malformed and unknown codes, mostly ignored
        case ($urandom_range(0, 4))
          0: k = rand_bits();
          1: k = KEY_W'($urandom_range(0, 8'h1f));
          2: k = KEY_W'($urandom_range(8'h7f, 8'hff));
          3: k = nav_key($urandom_range(0, 5)) ^ (56'h1 << $urandom_range(0, KEY_W - 1));
          default: k = $urandom_range(0, 1) ? 56'h1b5b : 56'h1b5b313b3541;
        endcase
        press(k);
      end else if (kind < 94) begin
        press(KEY_ESC);
      end else if (kind < 97) begin
        // type until full, then overflow on insert and on enter
        while (sb.len < LINE_LEN)
          press($urandom_range(0, 4) == 0 ? KEY_W'(CHAR_SPACE)
                                          : KEY_W'($urandom_range(8'h21, 8'h7e)));
        press(KEY_W'($urandom_range(8'h20, 8'h7e)));
        press(KEY_W'($urandom_range(8'h20, 8'h7e)));
        press(KEY_ENTER);
        filled = 1'b1;
      end else begin
        repeat ($urandom_range(2, 6)) press($urandom_range(0, 1) ? KEY_CLEFT : KEY_CRIGHT);
      end
    end

    start <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
